### src/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg: shared constants and types of the byte run-length compressor
// Holds the chunk limits, beat geometry, queue depth and the record types
// that pass between the front, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package brle_pkg;

	localparam int unsigned MAX_CHUNK  = 127;
	localparam int unsigned MIN_RUN    = 3;
	localparam int unsigned RUN_W      = $clog2(MAX_CHUNK + 1);
	localparam int unsigned CNT_W      = $clog2(MAX_CHUNK + 1);
	localparam int unsigned ADDR_W     = $clog2(MAX_CHUNK);
	localparam int unsigned BEAT_BYTES = 8;
	localparam int unsigned BCNT_W     = $clog2(BEAT_BYTES + 1);
	localparam int unsigned BIDX_W     = $clog2(BEAT_BYTES);
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FPTR_W     = $clog2(FIFO_DEPTH);

	// One resolved run handed from the front to the back end.
	// len below MIN_RUN: the bytes join the literal buffer.
	typedef struct packed {
		logic [7:0]       value;
		logic [RUN_W-1:0] len;
		logic             flush;  // flush literals after this run
		logic             eoi;    // last record caused by its input item
		logic             eob;    // item closes the block
	} op_t;

	typedef struct packed {
		logic                    eob;
		logic                    eoi;
		logic [BCNT_W-1:0]       cnt;
		logic [BEAT_BYTES*8-1:0] data;
	} beat_t;

endpackage

`default_nettype wire

### src/byte_rle_compressor.sv
// ----------------------------------------------------------------------------
// byte_rle_compressor: streaming byte run-length encoder
// Input beats on s_*: one raw byte each, s_tlast on the final byte of a block.
// Output beats on m_*: up to eight compressed bytes packed from the low byte,
// with their count; m_tuser marks the last beat caused by one input byte and
// m_tlast the final beat of the block. Bytes that only extend or start a run
// produce no beat.
// Throughput: a byte that extends a run only lengthens it. A byte that ends
// a run queues a run record; the encoder stores its literals and writes its
// compressed bytes, paced by the one-byte-a-cycle write path (it waits while
// a full beat cannot spill) and the single read port of the literal store.
// The record queue is four deep; s_tready drops when it is full or when an
// end-of-block byte still has a second record to queue.
// Output timing: the closing beat of an item loads from the end state, after
// the post state that follows the item's last write; a full beat turns valid
// the cycle after the next byte of the same item reaches the packer.
// Reset clears the run, the literal count, the queue and the output valid flag;
// the literal store needs no clearing. A stalled receiver holds the beat in
// the output register, then the packer, the encoder and the queue back up.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_rle_compressor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte
	input  wire logic        s_tlast,   // end_of_block
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // byte_0..byte_7 [63:0], valid_bytes [67:64], zero
	output logic             m_tuser,   // last_of_item
	output logic             m_tlast    // block_done
);

	import brle_pkg::*;

	logic  push;
	op_t   push_op;
	logic  full;
	logic  pop;
	op_t   head;
	logic  empty;
	beat_t beat;

	brle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.push     (push),
		.push_op  (push_op),
		.full     (full)
	);

	brle_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.head    (head),
		.empty   (empty)
	);

	brle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_beat  (beat)
	);

	assign m_tdata = {4'd0, 4'(beat.cnt), beat.data};
	assign m_tuser = beat.eoi;
	assign m_tlast = beat.eob;

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd8))
		else $error("beat byte count out of range");

	a_partial_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[67:64] != 4'd8) |-> m_tuser)
		else $error("partial beat not marked as last of item");

	a_block_item: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser)
		else $error("block end without item end");
`endif

endmodule

`default_nettype wire

### src/brle_ram.sv
// ----------------------------------------------------------------------------
// brle_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### src/brle_front.sv
// ----------------------------------------------------------------------------
// brle_front: run tracker
// Accepts raw bytes, extends or ends the candidate run and emits one record
// per resolved run into the queue. An end-of-block byte may cause two.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_last,
	output logic               push,
	output brle_pkg::op_t      push_op,
	input  wire logic          full
);

	import brle_pkg::*;

	logic [7:0]       run_val_q;
	logic [RUN_W-1:0] run_len_q;
	logic             pend_q;
	op_t              pend_op_q;

	logic cont;
	logic has_prev;
	logic accept;
	op_t  prev_op;
	op_t  cur_op;

	always_comb begin
		in_ready = !pend_q && !full;
		accept   = in_valid && in_ready;
		has_prev = (run_len_q != '0);
		cont     = has_prev && (in_byte == run_val_q) &&
		           (run_len_q != RUN_W'(MAX_CHUNK));

		prev_op.value = run_val_q;
		prev_op.len   = run_len_q;
		prev_op.flush = 1'b0;
		prev_op.eoi   = !in_last;
		prev_op.eob   = 1'b0;

		cur_op.value = cont ? run_val_q : in_byte;
		cur_op.len   = cont ? RUN_W'(run_len_q + 1'b1) : RUN_W'(1);
		cur_op.flush = 1'b1;
		cur_op.eoi   = 1'b1;
		cur_op.eob   = 1'b1;

		push    = 1'b0;
		push_op = cur_op;
		if (pend_q) begin
			push    = !full;
			push_op = pend_op_q;
		end else if (accept) begin
			if (!cont && has_prev) begin
				push    = 1'b1;
				push_op = prev_op;
			end else begin
				push = in_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_val_q <= '0;
			run_len_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (pend_q && !full) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				if (in_last) begin
					run_val_q <= '0;
					run_len_q <= '0;
					// hold the closing record while the previous run goes first
					pend_q    <= !cont && has_prev;
				end else if (cont) begin
					run_len_q <= RUN_W'(run_len_q + 1'b1);
				end else begin
					run_val_q <= in_byte;
					run_len_q <= RUN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_op_q <= cur_op;
		end
	end

endmodule

`default_nettype wire

### src/brle_fifo.sv
// ----------------------------------------------------------------------------
// brle_fifo: run record queue
// Short first-in first-out queue between the run tracker and the encoder,
// with the head record visible while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire brle_pkg::op_t push_op,
	output logic               full,
	input  wire logic          pop,
	output brle_pkg::op_t      head,
	output logic               empty
);

	import brle_pkg::*;

	op_t               mem_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [FPTR_W:0]   cnt_q;

	logic do_push;
	logic do_pop;

	always_comb begin
		full    = (cnt_q == (FPTR_W + 1)'(FIFO_DEPTH));
		empty   = (cnt_q == '0);
		head    = mem_q[rd_ptr_q];
		do_push = push && !full;
		do_pop  = pop && !empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= FPTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= FPTR_W'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= (FPTR_W + 1)'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= (FPTR_W + 1)'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

### src/brle_back.sv
// ----------------------------------------------------------------------------
// brle_back: encoder and beat packer
// Carries out run records: buffers literals in the literal store, writes
// literal chunks and run codes one byte a cycle while the packer can take
// them, and packs the bytes into beats held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brle_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire brle_pkg::op_t head,
	input  wire logic          empty,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output brle_pkg::beat_t    out_beat
);

	import brle_pkg::*;

	typedef enum logic [7:0] {
		B_IDLE = 8'b0000_0001,
		B_ADD  = 8'b0000_0010,
		B_FCNT = 8'b0000_0100,
		B_FDAT = 8'b0000_1000,
		B_RHDR = 8'b0001_0000,
		B_RVAL = 8'b0010_0000,
		B_POST = 8'b0100_0000,
		B_END  = 8'b1000_0000
	} bstate_t;

	bstate_t          state_q;
	bstate_t          state_d;
	op_t              cur_q;
	logic [1:0]       adds_q;
	logic             run_sent_q;
	logic [CNT_W-1:0] lit_cnt_q;
	logic [CNT_W-1:0] idx_q;

	logic [7:0]        pack_q [BEAT_BYTES];
	logic [BCNT_W-1:0] bcnt_q;
	logic              ov_q;
	beat_t             beat_q;

	logic              byte_v;
	logic [7:0]        byte_d;
	logic              byte_rdy;
	logic              close_v;
	logic              out_free;
	logic              pk_full;
	logic              load_full;
	logic              load_close;
	logic              is_run;
	logic              last_idx;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [CNT_W-1:0]  raddr_n;
	logic [7:0]        rdata;
	logic [CNT_W-1:0]  lit_inc;
	logic [BEAT_BYTES*8-1:0] masked;

	brle_ram #(
		.WIDTH (8),
		.DEPTH (MAX_CHUNK)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cur_q.value),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		out_free   = !ov_q || out_ready;
		pk_full    = (bcnt_q == BCNT_W'(BEAT_BYTES));
		byte_rdy   = !pk_full || out_free;
		is_run     = (cur_q.len >= RUN_W'(MIN_RUN));
		last_idx   = (idx_q == CNT_W'(lit_cnt_q - 1'b1));
		lit_inc    = CNT_W'(lit_cnt_q + 1'b1);
		waddr      = lit_cnt_q[ADDR_W-1:0];

		state_d = state_q;
		pop     = 1'b0;
		we      = 1'b0;
		byte_v  = 1'b0;
		byte_d  = cur_q.value;
		close_v = 1'b0;
		raddr_n = '0;

		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (head.len >= RUN_W'(MIN_RUN)) begin
						state_d = (lit_cnt_q != '0) ? B_FCNT : B_RHDR;
					end else begin
						state_d = B_ADD;
					end
				end
			end
			B_ADD: begin
				we = 1'b1;
				if (lit_inc == CNT_W'(MAX_CHUNK)) begin
					state_d = B_FCNT;
				end else if (adds_q == 2'd1) begin
					state_d = B_POST;
				end
			end
			B_FCNT: begin
				byte_v = 1'b1;
				byte_d = 8'(lit_cnt_q);
				if (byte_rdy) begin
					state_d = B_FDAT;
				end
			end
			B_FDAT: begin
				byte_v  = 1'b1;
				byte_d  = rdata;
				raddr_n = idx_q;
				if (byte_rdy) begin
					if (last_idx) begin
						raddr_n = '0;
						if (is_run && !run_sent_q) begin
							state_d = B_RHDR;
						end else if (adds_q != 2'd0) begin
							state_d = B_ADD;
						end else begin
							state_d = B_POST;
						end
					end else begin
						raddr_n = CNT_W'(idx_q + 1'b1);
					end
				end
			end
			B_RHDR: begin
				byte_v = 1'b1;
				byte_d = 8'(9'd256 - 9'(cur_q.len));
				if (byte_rdy) begin
					state_d = B_RVAL;
				end
			end
			B_RVAL: begin
				byte_v = 1'b1;
				byte_d = cur_q.value;
				if (byte_rdy) begin
					state_d = B_POST;
				end
			end
			B_POST: begin
				state_d = (cur_q.flush && lit_cnt_q != '0) ? B_FCNT : B_END;
			end
			B_END: begin
				if (cur_q.eoi && bcnt_q != '0) begin
					close_v = 1'b1;
					if (out_free) begin
						state_d = B_IDLE;
					end
				end else begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase

		raddr      = raddr_n[ADDR_W-1:0];
		load_full  = byte_v && pk_full && out_free;
		load_close = close_v && out_free;

		for (int i = 0; i < BEAT_BYTES; i++) begin
			masked[i*8 +: 8] = (BCNT_W'(i) < bcnt_q) ? pack_q[i] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			lit_cnt_q  <= '0;
			bcnt_q     <= '0;
			ov_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_ADD) begin
				lit_cnt_q <= lit_inc;
			end
			if (state_q == B_FDAT && byte_rdy && last_idx) begin
				lit_cnt_q <= '0;
			end
			if (byte_v && byte_rdy) begin
				bcnt_q <= pk_full ? BCNT_W'(1) : BCNT_W'(bcnt_q + 1'b1);
			end
			if (load_close) begin
				bcnt_q <= '0;
			end
			if (load_full || load_close) begin
				ov_q <= 1'b1;
			end else if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q      <= head;
			adds_q     <= head.len[1:0];
			run_sent_q <= 1'b0;
		end
		if (state_q == B_ADD) begin
			adds_q <= 2'(adds_q - 1'b1);
		end
		if (state_q == B_FCNT) begin
			idx_q <= '0;
		end else if (state_q == B_FDAT && byte_rdy) begin
			idx_q <= CNT_W'(idx_q + 1'b1);
		end
		if (state_q == B_RVAL && byte_rdy) begin
			run_sent_q <= 1'b1;
		end
		// a full beat spills to the output register as the next byte is taken
		if (byte_v && byte_rdy) begin
			if (pk_full) begin
				pack_q[0] <= byte_d;
			end else begin
				pack_q[bcnt_q[BIDX_W-1:0]] <= byte_d;
			end
		end
		if (load_full || load_close) begin
			beat_q.data <= masked;
			beat_q.cnt  <= bcnt_q;
			beat_q.eoi  <= load_close;
			beat_q.eob  <= load_close && cur_q.eob;
		end
	end

	assign out_valid = ov_q;
	assign out_beat  = beat_q;

endmodule

`default_nettype wire

### bench/tb_byte_rle_compressor.sv
// ----------------------------------------------------------------------------
// tb_byte_rle_compressor: self-checking bench for the byte run-length encoder
// Streams raw bytes into s_*, predicts the compressed beats of every accepted
// byte and checks each m_* beat in order against the prediction. Covers runs,
// literal chunks at the size limit and random traffic, under three idle
// patterns and one long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_byte_rle_compressor;

	import brle_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_STALL   = 500;
	localparam int DRAIN_CYCLES = 100;

	// Predicts the compressed beats of each accepted byte and holds them
	// until the block delivers them.
	class brle_scoreboard;
		logic [7:0]       lit_buf [MAX_CHUNK];
		logic [CNT_W-1:0] lit_cnt;
		logic [7:0]       cur_value;
		logic [RUN_W-1:0] cur_len;
		logic [7:0]       out_bytes [$];
		beat_t            beats_due [$];
		int               errors;

		function new();
			lit_cnt   = '0;
			cur_value = '0;
			cur_len   = '0;
			errors    = 0;
		endfunction

		function void flush_literals();
			if (lit_cnt == 0)
				return;
			out_bytes.push_back(8'(lit_cnt));
			for (int i = 0; i < int'(lit_cnt); i++)
				out_bytes.push_back(lit_buf[i]);
			lit_cnt = '0;
		endfunction

		function void add_literal(logic [7:0] v);
			lit_buf[lit_cnt] = v;
			lit_cnt++;
			if (lit_cnt == MAX_CHUNK)
				flush_literals();
		endfunction

		function void resolve_run();
			if (cur_len == 0)
				return;
			if (cur_len >= MIN_RUN) begin
				flush_literals();
				out_bytes.push_back(8'(9'd256 - 9'(cur_len)));
				out_bytes.push_back(cur_value);
			end else begin
				for (int i = 0; i < int'(cur_len); i++)
					add_literal(cur_value);
			end
			cur_len = '0;
		endfunction

		function void note_input(logic [7:0] d, logic eob);
			beat_t bt;
			int    pos;
			out_bytes.delete();
			if (cur_len != 0 && d == cur_value && cur_len < MAX_CHUNK) begin
				cur_len++;
			end else begin
				resolve_run();
				cur_value = d;
				cur_len   = 1;
			end
			if (eob) begin
				resolve_run();
				flush_literals();
				cur_value = '0;
			end
			// cut the byte stream into beats of eight, zeros past the count
			pos = 0;
			while (pos < out_bytes.size()) begin
				bt = '0;
				for (int j = 0; j < BEAT_BYTES && pos < out_bytes.size(); j++) begin
					bt.data[j*8 +: 8] = out_bytes[pos];
					pos++;
					bt.cnt++;
				end
				bt.eoi = (pos == out_bytes.size());
				bt.eob = bt.eoi && eob;
				beats_due.push_back(bt);
			end
		endfunction

		function void check_beat(logic [71:0] d, logic eoi, logic eob);
			beat_t want;
			if (beats_due.size() == 0) begin
				$error("beat with no expected result: tdata %h", d);
				errors++;
				return;
			end
			want = beats_due.pop_front();
			for (int j = 0; j < BEAT_BYTES; j++)
				if (d[j*8 +: 8] !== want.data[j*8 +: 8]) begin
					$error("byte_%0d: expected %h, actual %h", j,
						want.data[j*8 +: 8], d[j*8 +: 8]);
					errors++;
				end
			if (d[67:64] !== want.cnt) begin
				$error("valid_bytes: expected %0d, actual %0d", want.cnt, d[67:64]);
				errors++;
			end
			if (d[71:68] !== 4'd0) begin
				$error("tdata padding: expected 0, actual %h", d[71:68]);
				errors++;
			end
			if (eoi !== want.eoi) begin
				$error("last_of_item: expected %b, actual %b", want.eoi, eoi);
				errors++;
			end
			if (eob !== want.eob) begin
				$error("block_done: expected %b, actual %b", want.eob, eob);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // data_byte
	logic        s_tlast;    // end_of_block
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;    // byte_0..byte_7 [63:0], valid_bytes [67:64], zero
	logic        m_tuser;    // last_of_item
	logic        m_tlast;    // block_done

	brle_scoreboard sb = new();

	int         tx_idle   = 0;
	int         rx_idle   = 0;
	bit         stall_req = 1'b0;
	logic [7:0] prev_byte = '0;
	int         n_sent    = 0;
	int         cycles    = 0;

	byte_rle_compressor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL byte_rle_compressor");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_input(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tdata, m_tuser, m_tlast);
	end

	// receiver: random backpressure, or a long hold when asked
	initial begin : rx_side
		int hold;
		hold     = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				hold      = LONG_STALL;
				stall_req = 1'b0;
			end
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic eob);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= eob;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		prev_byte = d;
		n_sent++;
	endtask

	// each byte differs from its neighbor, so every one becomes a literal
	task automatic send_literals(input int n, input logic eob);
		logic [7:0] v;
		for (int i = 0; i < n; i++) begin
			do
				v = 8'($urandom);
			while (v == prev_byte);
			send_byte(v, eob && (i == n - 1));
		end
	endtask

	task automatic send_run(input logic [7:0] v, input int n, input logic eob);
		for (int i = 0; i < n; i++)
			send_byte(v, eob && (i == n - 1));
	endtask

	task automatic random_traffic(input int n);
		int   stop_at;
		int   r;
		logic eob;
		stop_at = n_sent + n;
		while (n_sent < stop_at) begin
			r   = $urandom_range(99);
			eob = ($urandom_range(99) < 15);
			if (r < 40)
				send_literals($urandom_range(1, 6), eob);
			else if (r < 75)
				send_run(8'($urandom), $urandom_range(3, 9), eob);
			else if (r < 88)
				send_run(8'($urandom), $urandom_range(1, 2), eob);
			else
				send_byte(8'($urandom), 1'($urandom_range(1)));
		end
	endtask

	initial begin : stimulus
		// {end_of_block, data_byte}
		logic [8:0] directed [] = '{
			{1'b1, 8'h00},                                   // single-byte block
			{1'b0, 8'hFF}, {1'b1, 8'hFF},                    // pair stays literal
			{1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, 8'h00},     // shortest coded run
			{1'b0, 8'hA5}, {1'b0, 8'h5A},                    // literals, then a run
			{1'b0, 8'h77}, {1'b0, 8'h77}, {1'b0, 8'h77}, {1'b1, 8'h77},
			{1'b0, 8'h11}, {1'b0, 8'h11}, {1'b0, 8'h11},     // run ends on new byte
			{1'b0, 8'h22}, {1'b1, 8'h22},
			{1'b0, 8'h7F}, {1'b0, 8'h80}, {1'b0, 8'h01}, {1'b1, 8'hFE}
		};
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 15;
		rx_idle = 60;
		foreach (directed[i])
			send_byte(directed[i][7:0], directed[i][8]);
		random_traffic(12);

		tx_idle = 60;
		rx_idle = 15;
		random_traffic(12);

		// hold the receiver while bytes keep coming, so the input backs up;
		// the literal buffer reaches its limit and flushes mid-stream
		tx_idle   = 0;
		rx_idle   = 0;
		stall_req = 1'b1;
		send_literals(130, 1'b0);
		send_byte(8'($urandom), 1'b1);
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (sb.beats_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS byte_rle_compressor");
		else
			$display("FAIL byte_rle_compressor");
		$finish;
	end

endmodule

### filelist.f
src/brle_pkg.sv
src/brle_ram.sv
src/brle_front.sv
src/brle_fifo.sv
src/brle_back.sv
src/byte_rle_compressor.sv
bench/tb_byte_rle_compressor.sv
